// ===== rtl/core/gftq_pkg.sv =====
`default_nettype none
package gftq_pkg;

  localparam int TEAMS       = 64;
  localparam int ELEMENT_IDS = 1024;
  localparam int CAPACITY    = 1024;

  localparam int ELEM_W = 10;
  localparam int TEAM_W = 6;
  localparam int POS_W  = $clog2(CAPACITY);
  localparam int CNT_W  = POS_W + 1;
  localparam int MADR_W = $clog2(ELEMENT_IDS);

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [TEAM_W-1:0] team_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [MADR_W-1:0] madr_t;

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_ASSIGN = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_DEQ_EMPTY = 2'd1,
    STAT_ENQ_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    elem_t element;
    team_t team;
  } entry_t;

  // Broadcast to every cell of the queue chain.
  typedef struct packed {
    logic   shift_out;
    logic   insert;
    pos_t   pos;
    entry_t ent;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/gftq_if.sv =====
`default_nettype none
interface gftq_req_if import gftq_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  elem_t       element;
  team_t       team;

  modport source (output valid, output command, output element, output team, input ready);
  modport sink   (input valid, input command, input element, input team, output ready);
endinterface

interface gftq_rsp_if import gftq_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        data_valid;
  elem_t       element_out;
  logic [1:0]  status;

  modport source (output valid, output data_valid, output element_out, output status,
                  input ready);
  modport sink   (input valid, input data_valid, input element_out, input status,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/grouped_fifo_team_queue.sv =====
// Channel  Role    Payload                          Handshake
// req      sink    command, element, team           valid / ready
// rsp      source  data_valid, element_out, status  valid / ready
//
// Each request is accepted in the idle state, where the registered read of the
// membership memory is taken, and is then executed in the execute state.
// A result waiting in the output register does not block acceptance; execution
// waits only when a new result is ready and the previous one is still held.
// After reset a clearing pass over all 1024 entries zeroes the membership
// memory, and no request is accepted until it ends.
`default_nettype none
module grouped_fifo_team_queue import gftq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  gftq_req_if.sink          req,
  gftq_rsp_if.source        rsp
);

  state_t     state;
  state_t     state_next;
  madr_t      clr_addr;
  logic       clearing;
  logic       acc;
  logic       exec_go;

  team_t      membership [ELEMENT_IDS];
  madr_t      mem_addr;
  logic       mem_we;
  team_t      mem_wdata;
  team_t      rd_team;

  cmd_t       cmd_r;
  elem_t      elem_r;
  cnt_t       count;

  entry_t              chain [CAPACITY];
  logic [CAPACITY-1:0] hits;
  cell_ctrl_t          cell_ctrl;
  logic                clr_cmd;
  logic                run_found;
  pos_t                run_end;
  pos_t                ins_pos;
  logic                full;
  logic                empty;
  logic                enq_ok;
  logic                deq_ok;
  status_t             status_now;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == madr_t'(ELEMENT_IDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = (state == ST_CLEAR);
    req.ready = (state == ST_IDLE);
    exec_go   = (state == ST_EXEC) && (!rsp.valid || rsp.ready);
  end

  assign acc = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_addr <= clr_addr + 1'b1;
    end
  end

  // Membership memory: one port, zeroed by the clearing pass, written by
  // assign requests and read for every accepted request.
  assign mem_addr  = clearing ? clr_addr : madr_t'(req.element);
  assign mem_we    = clearing || (acc && cmd_t'(req.command) == CMD_ASSIGN);
  assign mem_wdata = clearing ? '0 : req.team;

  always_ff @(posedge clk) begin
    if (mem_we) membership[mem_addr] <= mem_wdata;
    if (acc) rd_team <= membership[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r  <= cmd_t'(req.command);
      elem_r <= req.element;
    end
  end

  assign full    = (count == cnt_t'(CAPACITY));
  assign empty   = (count == '0);
  assign enq_ok  = (cmd_r == CMD_ENQ) && !full;
  assign deq_ok  = (cmd_r == CMD_DEQ) && !empty;
  assign clr_cmd = exec_go && (cmd_r == CMD_CLEAR);
  // A team already queued gets the slot right behind its run, any other team
  // goes at the overall tail.
  assign ins_pos = run_found ? run_end + 1'b1 : count[POS_W-1:0];

  always_comb begin
    cell_ctrl.shift_out = exec_go && deq_ok;
    cell_ctrl.insert    = exec_go && enq_ok;
    cell_ctrl.pos       = ins_pos;
    cell_ctrl.ent       = '{element: elem_r, team: rd_team};
  end

  always_comb begin
    status_now = STAT_OK;
    case (cmd_r)
      CMD_ENQ: if (full) status_now = STAT_ENQ_FULL;
      CMD_DEQ: if (empty) status_now = STAT_DEQ_EMPTY;
      default: status_now = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clr_cmd) begin
      count <= '0;
    end else if (cell_ctrl.insert) begin
      count <= count + 1'b1;
    end else if (cell_ctrl.shift_out) begin
      count <= count - 1'b1;
    end
  end

  gftq_team_tbl u_team_tbl (
    .hit     (hits),
    .found   (run_found),
    .run_end (run_end)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;

    if (i == 0) begin : g_first
      assign prev_ent = cell_ctrl.ent;
    end else begin : g_mid
      assign prev_ent = chain[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_ent = cell_ctrl.ent;
    end else begin : g_body
      assign next_ent = chain[i+1];
    end

    gftq_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .key      (rd_team),
      .fill     (count),
      .idx      (pos_t'(i)),
      .prev_ent (prev_ent),
      .next_ent (next_ent),
      .ent      (chain[i]),
      .hit      (hits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (exec_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp.data_valid  <= deq_ok;
      rsp.element_out <= deq_ok ? chain[0].element : '0;
      rsp.status      <= status_now;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gftq_cell.sv =====
`default_nettype none
module gftq_cell import gftq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  team_t      key,
  input  cnt_t       fill,
  input  pos_t       idx,
  input  entry_t     prev_ent,
  input  entry_t     next_ent,
  output entry_t     ent,
  output logic       hit
);

  // Only cells below the fill level hold a queued entry.
  assign hit = (cnt_t'(idx) < fill) && (ent.team == key);

  // A dequeue moves every entry one place toward the head. An insert opens a
  // gap at the chosen position by moving the entries behind it one place back.
  always_ff @(posedge clk) begin
    if (ctrl.shift_out) begin
      ent <= next_ent;
    end else if (ctrl.insert) begin
      if (idx == ctrl.pos) begin
        ent <= ctrl.ent;
      end else if (idx > ctrl.pos) begin
        ent <= prev_ent;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gftq_team_tbl.sv =====
`default_nettype none
module gftq_team_tbl import gftq_pkg::*; (
  input  logic [CAPACITY-1:0] hit,
  output logic                found,
  output pos_t                run_end
);

  logic [CAPACITY-1:0] last;

  // Runs are contiguous, so at most one cell holds the last member of a team.
  assign last  = hit & ~(hit >> 1);
  assign found = |hit;

  always_comb begin
    run_end = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (last[j]) run_end = run_end | pos_t'(j);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gftq_checker.sv =====
`default_nettype none
module gftq_checker import gftq_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_data_valid,
  input elem_t      rsp_element_out,
  input logic [1:0] rsp_status
);

  // Requests are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another was in progress");

  // A new result appears only after a request was being executed.
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without an executed request");

  // Returned data always comes with an ok status.
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data_valid |-> rsp_status == STAT_OK)
    else $error("returned element with an error status");

  // The membership clearing pass keeps requests out right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !req_ready)
    else $error("request taken during the clearing pass");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element_out)
                                && $stable(rsp_status) && $stable(rsp_data_valid))
    else $error("stalled result changed");

endmodule

bind grouped_fifo_team_queue gftq_checker u_gftq_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_data_valid  (rsp.data_valid),
  .rsp_element_out (rsp.element_out),
  .rsp_status      (rsp.status)
);
`default_nettype wire
